// ===== hdl/asf_pkg.sv =====
// shared types and constants of the anaglyph shift filter
package asf_pkg;

    localparam int PIX_W    = 8;
    localparam int SHIFT_W  = 6;
    localparam int LWIDTH_W = 13;
    localparam int GSRC_W   = 2;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_RING_DEPTH = 128;

    localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 6'd5;
    localparam logic [LWIDTH_W-1:0] LWIDTH_RST = 13'd640;
    localparam logic [GSRC_W-1:0]   GSRC_RST   = 2'd2;

    // register word index (paddr[3:2])
    localparam logic [1:0] REG_SHIFT  = 2'd0;
    localparam logic [1:0] REG_LWIDTH = 2'd1;
    localparam logic [1:0] REG_GSRC   = 2'd2;

    // green source codes
    localparam logic [GSRC_W-1:0] GSRC_ZERO   = 2'd0;
    localparam logic [GSRC_W-1:0] GSRC_CENTRE = 2'd1;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        t_pix pix;
        logic row_end;
    } t_opix;

endpackage

// ===== hdl/asf_in_if.sv =====
// input pixel channel
interface asf_in_if
    import asf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;

    modport source (output valid, output in_red, output in_green, output in_blue, input ready);
    modport sink (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

// ===== hdl/asf_out_if.sv =====
// result pixel channel
interface asf_out_if
    import asf_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             row_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output row_end, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input row_end, output ready);
endinterface

// ===== hdl/asf_ram.sv =====
// generic synchronous ram, one write port, registered read ports
module asf_ram #(
    parameter int WIDTH    = 24,
    parameter int DEPTH    = 128,
    parameter int RD_PORTS = 1,
    localparam int AW      = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr [RD_PORTS],
    output logic [WIDTH-1:0] o_rdata [RD_PORTS]
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        for (int p = 0; p < RD_PORTS; p++) begin
            o_rdata[p] <= r_mem[i_raddr[p]];
        end
    end

endmodule

// ===== hdl/anaglyph_shift_filter.sv =====
// anaglyph shift filter: top level
//
// Pixels enter on i_pix in raster order, one row of line_width pixels after
// another. Each beat writes the pixel into a ring memory (RING_DEPTH entries,
// a power of two) and issues at most one result read. A result pixel for
// column x reads left (x-shift), centre (x) and right (x+shift) from two ring
// copies, is registered in the read stage, then in the output queue, and leaves
// on o_pix. One pixel is taken per cycle while i_pix.ready is high; the beat
// that ends a row also starts a flush of the remaining shift pixels of the
// row, one per cycle while the queue has room, during which i_pix.ready stays low.
// Results go through a four-entry output queue; when the receiver stalls the
// queue fills and i_pix.ready drops until space frees up.
// The APB port holds shift (0x0), line_width (0x4) and green_source (0x8). The user
// must make writes only while no pixel is in flight, which the block does not enforce;
// writes apply from the next beat. Reset clears the column count, the flush and the
// queue and loads shift 5, line_width 640 and green_source 2. The ring is not cleared.
module anaglyph_shift_filter
    import asf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    asf_in_if.sink            i_pix,
    asf_out_if.source         o_pix,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = $clog2(MAX_WIDTH + 1);
    localparam int SW   = ((EW > SHIFT_W + 1) ? EW : SHIFT_W + 1) + 1;
    localparam int CMPW = (EW > LWIDTH_W) ? EW : LWIDTH_W;
    localparam int RAW  = $clog2(RING_DEPTH);
    localparam int PW   = $bits(t_pix);
    localparam int FIFO_DEPTH = 4;
    localparam int FAW  = $clog2(FIFO_DEPTH);
    localparam int FCW  = $clog2(FIFO_DEPTH + 1);

    // configuration registers
    logic [SHIFT_W-1:0]  r_shift;
    logic [LWIDTH_W-1:0] r_lwidth;
    logic [GSRC_W-1:0]   r_gsel;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= SHIFT_RST;
            r_lwidth <= LWIDTH_RST;
            r_gsel   <= GSRC_RST;
        end else if (cfg_wr) begin
            case (paddr[APB_AW-1:2])
                REG_SHIFT:  r_shift  <= pwdata[SHIFT_W-1:0];
                REG_LWIDTH: r_lwidth <= pwdata[LWIDTH_W-1:0];
                REG_GSRC:   r_gsel   <= pwdata[GSRC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[APB_AW-1:2])
            REG_SHIFT:  prdata = APB_DW'(r_shift);
            REG_LWIDTH: prdata = APB_DW'(r_lwidth);
            REG_GSRC:   prdata = APB_DW'(r_gsel);
            default:    prdata = '0;
        endcase
    end

    // effective width, clamped to 1..MAX_WIDTH
    logic [CMPW-1:0] w_raw;
    logic [CMPW-1:0] w_cmp;
    logic [SW-1:0]   w_s;
    logic [SW-1:0]   s_s;
    logic [SW-1:0]   c_s;

    assign w_raw = CMPW'(r_lwidth);

    always_comb begin
        if (w_raw == '0) begin
            w_cmp = CMPW'(1);
        end else if (w_raw > CMPW'(MAX_WIDTH)) begin
            w_cmp = CMPW'(MAX_WIDTH);
        end else begin
            w_cmp = w_raw;
        end
    end

    assign w_s = SW'(w_cmp[EW-1:0]);
    assign s_s = SW'(r_shift);

    // column count and row flush
    logic [CW-1:0] r_col;
    logic          r_flush;
    logic [CW-1:0] r_fx;
    logic [CW-1:0] r_fend;

    assign c_s = SW'(r_col);

    logic          acc;
    logic          last;
    logic          pass;
    logic          c_ge_s;
    logic [CW-1:0] c_minus_s;
    logic          a_emit;
    logic [CW-1:0] a_x;
    logic          a_end;
    logic          a_flush;

    logic [FCW-1:0] r_cnt;
    logic           r_s1_valid;
    logic           room;

    assign room      = (r_cnt + FCW'(r_s1_valid)) < FCW'(FIFO_DEPTH);
    assign i_pix.ready = !r_flush && room;
    assign acc       = i_pix.valid && i_pix.ready;
    assign last      = (c_s + SW'(1)) >= w_s;
    assign pass      = w_s <= SW'({r_shift, 1'b1});
    assign c_ge_s    = c_s >= s_s;
    assign c_minus_s = CW'(c_s - s_s);

    always_comb begin
        a_emit  = 1'b0;
        a_x     = r_col;
        a_end   = 1'b0;
        a_flush = 1'b0;
        if (pass) begin
            a_emit = 1'b1;
            a_end  = last;
        end else if (last) begin
            a_emit  = 1'b1;
            a_x     = c_ge_s ? c_minus_s : '0;
            a_end   = (a_x == r_col);
            a_flush = !a_end;
        end else if (c_ge_s) begin
            a_emit = 1'b1;
            a_x    = c_minus_s;
        end
    end

    // result read issue
    logic           f_iss;
    logic           f_end;
    logic           iss_valid;
    logic [CW-1:0]  iss_x;
    logic           iss_end;
    logic [SW-1:0]  x_s;
    logic           iss_mod;
    logic [RAW-1:0] x_lo;
    logic [RAW-1:0] s_lo;
    logic [RAW-1:0] ad_l;
    logic [RAW-1:0] ad_r;
    logic [RAW-1:0] wr_a;
    t_pix           in_px;

    assign f_iss     = r_flush && room;
    assign f_end     = (r_fx == r_fend);
    assign iss_valid = (acc && a_emit) || f_iss;
    assign iss_x     = r_flush ? r_fx : a_x;
    assign iss_end   = r_flush ? f_end : a_end;
    assign x_s       = SW'(iss_x);
    assign iss_mod   = (x_s > s_s) && ((x_s + s_s) < w_s);
    assign x_lo      = RAW'(iss_x);
    assign s_lo      = RAW'(r_shift);
    assign ad_l      = x_lo - s_lo;
    assign ad_r      = x_lo + s_lo;
    assign wr_a      = RAW'(r_col);
    assign in_px     = '{red: i_pix.in_red, green: i_pix.in_green, blue: i_pix.in_blue};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_flush <= 1'b0;
        end else begin
            if (acc) begin
                r_col <= last ? '0 : r_col + CW'(1);
                if (a_flush) begin
                    r_flush <= 1'b1;
                    r_fx    <= a_x + CW'(1);
                    r_fend  <= r_col;
                end
            end
            if (f_iss) begin
                if (f_end) begin
                    r_flush <= 1'b0;
                end else begin
                    r_fx <= r_fx + CW'(1);
                end
            end
        end
    end

    // ring memories: copy a serves left and centre, copy b serves right
    logic [RAW-1:0] ra_a [2];
    logic [RAW-1:0] ra_b [1];
    logic [PW-1:0]  rd_a [2];
    logic [PW-1:0]  rd_b [1];

    assign ra_a[0] = ad_l;
    assign ra_a[1] = x_lo;
    assign ra_b[0] = ad_r;

    asf_ram #(
        .WIDTH    (PW),
        .DEPTH    (RING_DEPTH),
        .RD_PORTS (2)
    ) u_ring_a (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (wr_a),
        .i_wdata (in_px),
        .i_raddr (ra_a),
        .o_rdata (rd_a)
    );

    asf_ram #(
        .WIDTH    (PW),
        .DEPTH    (RING_DEPTH),
        .RD_PORTS (1)
    ) u_ring_b (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (wr_a),
        .i_wdata (in_px),
        .i_raddr (ra_b),
        .o_rdata (rd_b)
    );

    // read stage; a read of the slot written on the same edge takes the new pixel
    logic              r_s1_mod;
    logic              r_s1_end;
    logic [GSRC_W-1:0] r_s1_gsel;
    logic              r_s1_fl;
    logic              r_s1_fc;
    logic              r_s1_fr;
    t_pix              r_s1_fpix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= iss_valid;
        end
        r_s1_mod  <= iss_mod;
        r_s1_end  <= iss_end;
        r_s1_gsel <= r_gsel;
        r_s1_fl   <= acc && (ad_l == wr_a);
        r_s1_fc   <= acc && (x_lo == wr_a);
        r_s1_fr   <= acc && (ad_r == wr_a);
        r_s1_fpix <= in_px;
    end

    t_pix  px_l;
    t_pix  px_c;
    t_pix  px_r;
    t_opix s1_res;

    assign px_l = r_s1_fl ? r_s1_fpix : t_pix'(rd_a[0]);
    assign px_c = r_s1_fc ? r_s1_fpix : t_pix'(rd_a[1]);
    assign px_r = r_s1_fr ? r_s1_fpix : t_pix'(rd_b[0]);

    always_comb begin
        s1_res.row_end = r_s1_end;
        if (r_s1_mod) begin
            s1_res.pix.red  = px_l.red;
            s1_res.pix.blue = px_r.blue;
            case (r_s1_gsel)
                GSRC_ZERO:   s1_res.pix.green = '0;
                GSRC_CENTRE: s1_res.pix.green = px_c.green;
                default:     s1_res.pix.green = px_r.green;
            endcase
        end else begin
            s1_res.pix = px_c;
        end
    end

    // output queue
    t_opix          r_fifo [FIFO_DEPTH];
    logic [FAW-1:0] r_wp;
    logic [FAW-1:0] r_rp;
    logic           pop;
    t_opix          head;

    assign head          = r_fifo[r_rp];
    assign o_pix.valid   = (r_cnt != '0);
    assign o_pix.out_red   = head.pix.red;
    assign o_pix.out_green = head.pix.green;
    assign o_pix.out_blue  = head.pix.blue;
    assign o_pix.row_end   = head.row_end;
    assign pop           = o_pix.valid && o_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_s1_valid) begin
                r_wp <= r_wp + FAW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FAW'(1);
            end
            r_cnt <= r_cnt + FCW'(r_s1_valid) - FCW'(pop);
        end
        if (r_s1_valid) begin
            r_fifo[r_wp] <= s1_res;
        end
    end

    // checks
    a_no_take_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> !i_pix.ready)
        else $error("input beat taken during row flush");

    a_row_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && last) |=> (r_col == '0))
        else $error("column count not cleared after last pixel of row");

    a_flush_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_flush) |-> $past(iss_end))
        else $error("flush stopped before the end of the row");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_cnt < FCW'(FIFO_DEPTH)) || pop)
        else $error("output queue overflow");

endmodule

// ===== test/anaglyph_shift_filter_test.sv =====
// self-checking testbench of the anaglyph shift filter: row predictor and ordered pixel compare
module anaglyph_shift_filter_test;
    import asf_pkg::*;

    localparam int LIMIT        = 1_000_000;
    localparam int SETTLE       = 80;
    localparam int MAX_REPORTED = 10;
    localparam int LONG_HOLD    = 300;

    localparam logic [GSRC_W-1:0] GSRC_RIGHT     = 2'd2;
    localparam logic [GSRC_W-1:0] GSRC_RIGHT_ALT = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    asf_in_if  in_ch ();
    asf_out_if out_ch ();

    anaglyph_shift_filter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (in_ch),
        .o_pix   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the row state and the registers
    t_pix              ring_copy [DEF_RING_DEPTH];
    int unsigned       next_col;
    int unsigned       cur_shift;
    int unsigned       cur_width;
    logic [GSRC_W-1:0] cur_gsrc;

    t_pix        pixels_to_send [$];
    t_opix       pixels_due [$];
    t_pix        tx_next;
    int unsigned beats_in   = 0;
    int unsigned mismatches = 0;
    int unsigned cycles     = 0;
    int unsigned tx_gap     = 0;
    int unsigned rx_gap     = 0;
    int unsigned hold_at    = 32'hFFFF_FFFF;
    bit          calm       = 1'b0;
    bit          rx_hold    = 1'b0;

    function automatic int unsigned row_len(int unsigned wd);
        if (wd == 0)
            return 1;
        if (wd > DEF_MAX_WIDTH)
            return DEF_MAX_WIDTH;
        return wd;
    endfunction

    function automatic t_pix shaded_pixel(int unsigned x, int unsigned w);
        t_pix centre;
        t_pix left;
        t_pix right;
        t_pix res;
        centre = ring_copy[x % DEF_RING_DEPTH];
        if (x > cur_shift && x + cur_shift < w) begin
            left      = ring_copy[(x - cur_shift) % DEF_RING_DEPTH];
            right     = ring_copy[(x + cur_shift) % DEF_RING_DEPTH];
            res.red   = left.red;
            res.blue  = right.blue;
            case (cur_gsrc)
                GSRC_ZERO:   res.green = '0;
                GSRC_CENTRE: res.green = centre.green;
                default:     res.green = right.green;
            endcase
        end else begin
            res = centre;
        end
        return res;
    endfunction

    // takes one input pixel and queues the result pixels it releases
    function automatic void advance_row(t_pix p);
        int unsigned w;
        int unsigned c;
        int unsigned x;
        bit          last;
        w    = row_len(cur_width);
        c    = next_col;
        last = (c + 1 >= w);
        ring_copy[c % DEF_RING_DEPTH] = p;
        if (w <= 2 * cur_shift + 1) begin
            pixels_due.push_back({shaded_pixel(c, w), last});
        end else if (last) begin
            // end of row: flush the tail
            for (x = (c >= cur_shift) ? c - cur_shift : 0; x <= c; x++)
                pixels_due.push_back({shaded_pixel(x, w), x == c});
        end else if (c >= cur_shift) begin
            pixels_due.push_back({shaded_pixel(c - cur_shift, w), 1'b0});
        end
        next_col = last ? 0 : c + 1;
    endfunction

    task automatic check_result();
        t_opix want;
        if (pixels_due.size() == 0) begin
            if (mismatches < MAX_REPORTED)
                $display("unexpected pixel r=%h g=%h b=%h row_end=%b",
                         out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.row_end);
            mismatches++;
        end else begin
            want = pixels_due.pop_front();
            if (out_ch.out_red !== want.pix.red || out_ch.out_green !== want.pix.green ||
                out_ch.out_blue !== want.pix.blue || out_ch.row_end !== want.row_end) begin
                if (mismatches < MAX_REPORTED)
                    $display("pixel mismatch: expected %h %h %h %b, got %h %h %h %b",
                             want.pix.red, want.pix.green, want.pix.blue, want.row_end,
                             out_ch.out_red, out_ch.out_green, out_ch.out_blue,
                             out_ch.row_end);
                mismatches++;
            end
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                advance_row({in_ch.in_red, in_ch.in_green, in_ch.in_blue});
                beats_in++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pixels_to_send.size() != 0) begin
                    tx_next = pixels_to_send.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.in_red   <= tx_next.red;
                    in_ch.in_green <= tx_next.green;
                    in_ch.in_blue  <= tx_next.blue;
                    if (!calm && $urandom_range(0, 7) == 0)
                        tx_gap = $urandom_range(1, 17);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready)
                check_result();
            if (rx_hold) begin
                out_ch.ready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                out_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(0, 16);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // long receiver stall so the output queue fills and input beats back up
    initial begin
        wait (beats_in >= hold_at);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [APB_DW-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SHIFT:  cur_shift = 32'(val[SHIFT_W-1:0]);
            REG_LWIDTH: cur_width = 32'(val[LWIDTH_W-1:0]);
            REG_GSRC:   cur_gsrc  = val[GSRC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic setup(int unsigned sh, int unsigned wd, logic [GSRC_W-1:0] gs);
        write_reg(REG_SHIFT, sh);
        write_reg(REG_LWIDTH, wd);
        write_reg(REG_GSRC, {30'd0, gs});
    endtask

    task automatic send_row(int unsigned n);
        repeat (n)
            pixels_to_send.push_back({8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255))});
    endtask

    // sampled on the falling edge to stay clear of the driver updates
    task automatic drain();
        while (pixels_to_send.size() != 0 || in_ch.valid || pixels_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin
        int unsigned rnd_items;
        int unsigned sh;
        int unsigned wd;
        int unsigned n;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.in_red   = '0;
        in_ch.in_green = '0;
        in_ch.in_blue  = '0;
        out_ch.ready   = 1'b0;
        cur_shift      = 32'(SHIFT_RST);
        cur_width      = 32'(LWIDTH_RST);
        cur_gsrc       = GSRC_RST;
        next_col       = 0;
        i_rst_n        = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // start of a row at the reset settings; the next settings end it
        send_row(8);
        drain();

        // width zero behaves as one: every pixel is a row of its own
        setup(0, 0, GSRC_ZERO);
        pixels_to_send.push_back(24'h000000);
        pixels_to_send.push_back(24'hFFFFFF);
        pixels_to_send.push_back(24'hFF00FF);
        drain();

        setup(2, 8, GSRC_CENTRE);
        for (int i = 0; i < 8; i++)
            pixels_to_send.push_back({8'(i * 36), 8'(255 - i * 36), 8'(i * 17 + 3)});
        pixels_to_send[0] = 24'hFFFFFF;
        pixels_to_send[7] = 24'h000000;
        drain();

        // selector three takes green from the right pixel
        setup(1, 5, GSRC_RIGHT_ALT);
        send_row(5);
        drain();

        // width equal to 2*shift+1: nothing changes, pixels pass straight through
        setup(2, 5, GSRC_CENTRE);
        send_row(5);
        drain();

        hold_at = beats_in + 8;
        setup(3, 16, GSRC_CENTRE);
        send_row(16);
        send_row(16);
        drain();

        rnd_items = 0;
        while (rnd_items < 40) begin
            sh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
            wd = $urandom_range(0, 12);
            setup(sh, wd, GSRC_W'($urandom_range(0, 3)));
            n = $urandom_range(1, 2);
            repeat (n) send_row(row_len(wd));
            rnd_items += n * row_len(wd);
            drain();
        end

        // width above the maximum is clipped; the row stays open
        setup(7, 8191, GSRC_ZERO);
        send_row(8);
        drain();

        calm = 1'b1;
        setup(4, 20, GSRC_RIGHT);
        repeat (2) send_row(20);
        drain();

        if (mismatches == 0 && pixels_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
